[design/ffe_pkg.sv]
// Shared types, constants and line phase codes for the flat-file field extractor.
package ffe_pkg;

    localparam int LABEL_COLUMNS_DEF = 12;
    localparam int NAME_CHARS = 12;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_TRAIL = 3'd2;
    localparam logic [2:0] PH_FAIL  = 3'd3;
    localparam logic [2:0] PH_COPY  = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    typedef struct packed {
        logic [7:0] char_in;
        logic       char_present;
        logic       line_last;
        logic       record_last;
    } ffe_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_present;
        logic       record_done;
    } ffe_result_t;

    typedef struct packed {
        ffe_result_t [2:0] slot;
        logic [1:0]        count;
    } ffe_bundle_t;

    typedef struct packed {
        logic [63:0] name_chars_low;
        logic [31:0] name_chars_high;
        logic [3:0]  name_length;
    } ffe_cfg_t;

endpackage

[design/ffe_input_stage.sv]
// Input holding register for one request, with stall towards the sender.
module ffe_input_stage
    import ffe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ffe_item_t in_item,
    input  logic      take,
    output logic      held_valid,
    output ffe_item_t held_item
);

    logic      full_reg;
    logic      full_next;
    ffe_item_t item_reg;
    logic      accept;

    assign in_stall   = full_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign held_valid = full_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[design/ffe_line_parser.sv]
// Per-line label matcher and decision logic producing the result group of each request.
module ffe_line_parser
    import ffe_pkg::*;
#(
    parameter int LABEL_COLUMNS = LABEL_COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ffe_cfg_t    cfg,
    input  logic        item_valid,
    input  ffe_item_t   item,
    input  logic        bundle_free,
    output logic        move,
    output ffe_bundle_t bundle
);

    localparam int CW = $clog2(LABEL_COLUMNS + 1);
    localparam logic [CW-1:0] LC_W = CW'(LABEL_COLUMNS);
    localparam logic [3:0] NAME_CHARS_W = 4'(NAME_CHARS);

    logic [CW-1:0] column_reg;
    logic [CW-1:0] column_next;
    logic [2:0]    phase_reg;
    logic [2:0]    phase_next;
    logic [3:0]    match_reg;
    logic [3:0]    match_next;
    logic          after_hit_reg;
    logic          after_hit_next;
    logic          nonempty_reg;
    logic          nonempty_next;

    logic [7:0]    name_bytes [NAME_CHARS];
    logic          line_end;
    logic          try_name;
    logic [3:0]    match_base;
    logic          decide_now;
    logic          emit_char;
    logic [1:0]    nl_count;
    logic [1:0]    n;

    assign move     = item_valid && bundle_free;
    assign line_end = item.line_last || item.record_last;

    always_comb
    begin
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (i < 8)
            begin
                name_bytes[i] = cfg.name_chars_low[8*i +: 8];
            end
            else
            begin
                name_bytes[i] = cfg.name_chars_high[8*(i-8) +: 8];
            end
        end
    end

    always_comb
    begin
        column_next    = column_reg;
        phase_next     = phase_reg;
        match_next     = match_reg;
        after_hit_next = after_hit_reg;
        nonempty_next  = nonempty_reg;
        try_name       = 1'b0;
        match_base     = match_reg;
        decide_now     = 1'b0;
        emit_char      = 1'b0;
        nl_count       = 2'd0;

        if (item.char_present)
        begin
            if (column_reg < LC_W)
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (item.char_in != CHAR_SPACE)
                        begin
                            try_name   = 1'b1;
                            match_base = 4'd0;
                        end
                    end
                    PH_NAME:
                    begin
                        try_name = 1'b1;
                    end
                    PH_TRAIL:
                    begin
                        if (item.char_in != CHAR_SPACE)
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (try_name)
                begin
                    match_next = match_base;
                    if ((match_base < cfg.name_length) && (match_base < NAME_CHARS_W)
                        && (name_bytes[match_base] == item.char_in))
                    begin
                        match_next = match_base + 4'd1;
                        phase_next = (match_next == cfg.name_length) ? PH_TRAIL : PH_NAME;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                column_next = column_reg + CW'(1);
                if (column_next == LC_W)
                begin
                    decide_now = 1'b1;
                end
            end
            else if (phase_reg == PH_COPY)
            begin
                emit_char     = 1'b1;
                nonempty_next = 1'b1;
            end
        end

        if (line_end && (phase_next != PH_COPY) && (phase_next != PH_SKIP))
        begin
            decide_now = 1'b1;
        end

        if (decide_now)
        begin
            if (after_hit_reg && (phase_next == PH_LEAD))
            begin
                nl_count      = 2'd1;
                nonempty_next = 1'b1;
                phase_next    = PH_COPY;
            end
            else if (phase_next == PH_TRAIL)
            begin
                nl_count       = nonempty_reg ? 2'd2 : 2'd0;
                after_hit_next = 1'b1;
                phase_next     = PH_COPY;
            end
            else
            begin
                after_hit_next = 1'b0;
                phase_next     = PH_SKIP;
            end
        end

        if (line_end)
        begin
            column_next = '0;
            phase_next  = PH_LEAD;
            match_next  = 4'd0;
        end

        if (item.record_last)
        begin
            after_hit_next = 1'b0;
            nonempty_next  = 1'b0;
        end
    end

    always_comb
    begin
        bundle = '0;
        n      = 2'd0;
        if (emit_char)
        begin
            bundle.slot[0] = '{out_char: item.char_in, out_present: 1'b1, record_done: 1'b0};
            n = 2'd1;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (2'(i) < nl_count)
                begin
                    bundle.slot[i] = '{out_char: CHAR_NEWLINE, out_present: 1'b1,
                                       record_done: 1'b0};
                end
            end
            n = nl_count;
        end
        if (item.record_last)
        begin
            bundle.slot[n] = '{out_char: 8'h00, out_present: 1'b0, record_done: 1'b1};
            n = n + 2'd1;
        end
        bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            phase_reg     <= PH_LEAD;
            match_reg     <= 4'd0;
            after_hit_reg <= 1'b0;
            nonempty_reg  <= 1'b0;
        end
        else if (move)
        begin
            column_reg    <= column_next;
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            after_hit_reg <= after_hit_next;
            nonempty_reg  <= nonempty_next;
        end
    end

    a_record_reset: assert property (@(posedge clk) disable iff (!rst_n)
        move && item.record_last |=> (column_reg == '0) && (phase_reg == PH_LEAD)
            && !after_hit_reg && !nonempty_reg)
        else $error("line state not cleared after record end");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= LC_W)
        else $error("column count beyond label width");

    a_three_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        move && (bundle.count == 2'd3) |-> bundle.slot[2].record_done)
        else $error("three results without terminator");

    a_copy_after_label: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COPY) || (phase_reg == PH_SKIP) |-> column_reg == LC_W
            || (column_reg == '0))
        else $error("line decided before label columns were seen");

endmodule

[design/ffe_result_queue.sv]
// Three-slot result register that hands out one result per handshake on the output side.
module ffe_result_queue
    import ffe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  ffe_bundle_t bundle,
    output logic        bundle_free,
    output logic        out_valid,
    input  logic        out_stall,
    output ffe_result_t head
);

    ffe_result_t [2:0] slot_reg;
    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    logic              out_accept;

    assign out_valid   = rem_reg != 2'd0;
    assign out_accept  = out_valid && !out_stall;
    assign bundle_free = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_accept);
    assign head        = slot_reg[0];

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = bundle.count;
        end
        else if (out_accept)
        begin
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.slot;
        end
        else if (out_accept)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && (bundle.count != 2'd0) |=> rem_reg == $past(bundle.count))
        else $error("result group not taken in full");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && !load |=> rem_reg == $past(rem_reg) - 2'd1)
        else $error("result count not stepped on hand-out");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> (rem_reg == $past(rem_reg)) && $stable(slot_reg[0]))
        else $error("pending result changed under stall");

endmodule

[design/flat_file_field_extractor.sv]
// Flat-file field extractor: streams the text of one configured header field.
//
// Input channel: one character request per handshake (char_in, char_present,
// line_last, record_last), taken when in_valid is high and in_stall is low.
// Output channel: one result per handshake (out_char, out_present,
// record_done), taken when out_valid is high and out_stall is low.
// Configuration: cfg_write with cfg_index 0, 1, 2 writes name_chars_low,
// name_chars_high, name_length; write only while the block is idle.
// Order: a request is held in the input register, then its results are loaded
// into the output register once that register is free; the first result is
// visible there and is taken by the output handshake.
// Throughput: one request per cycle while each request gives at most one
// result and out_stall is low. A request giving k results (newline bursts,
// record terminator) occupies the output register until all k are taken.
// Reset: clears the line state, the result register and the configuration.
// Stall: a stalled result holds; one further request is held in the input
// register before in_stall rises.
module flat_file_field_extractor
    import ffe_pkg::*;
#(
    parameter int LABEL_COLUMNS = LABEL_COLUMNS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_in,
    input  logic                  char_present,
    input  logic                  line_last,
    input  logic                  record_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_char,
    output logic                  out_present,
    output logic                  record_done
);

    ffe_cfg_t    cfg_reg;
    ffe_item_t   in_item;
    ffe_item_t   held_item;
    logic        held_valid;
    logic        move;
    logic        bundle_free;
    ffe_bundle_t bundle;
    ffe_result_t head;

    assign in_item = '{char_in: char_in, char_present: char_present,
                       line_last: line_last, record_last: record_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NAME_LOW:  cfg_reg.name_chars_low  <= cfg_data[63:0];
                REG_NAME_HIGH: cfg_reg.name_chars_high <= cfg_data[31:0];
                REG_NAME_LEN:  cfg_reg.name_length     <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    ffe_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (move),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ffe_line_parser #(
        .LABEL_COLUMNS (LABEL_COLUMNS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (held_valid),
        .item        (held_item),
        .bundle_free (bundle_free),
        .move        (move),
        .bundle      (bundle)
    );

    ffe_result_queue u_results (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (move),
        .bundle      (bundle),
        .bundle_free (bundle_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .head        (head)
    );

    assign out_char    = head.out_char;
    assign out_present = head.out_present;
    assign record_done = head.record_done;

endmodule
